@@ rtl/pn2d_pkg.sv @@
package pn2d_pkg;

    // Field widths of the command and response items.
    localparam int COORD_W = 24;
    localparam int IDX_W   = 8;
    localparam int NOISE_W = 17;

    // Permutation table size and the largest legal noise value (1.0 in Q1.16).
    localparam int PERM_DEPTH = 256;
    localparam logic [NOISE_W-1:0] NOISE_MAX = NOISE_W'(65536);

    // Defaults for the top level parameters.
    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 16;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } opcode_t;

    typedef logic [IDX_W-1:0] perm_byte_t;

    // Table access from the top level: one write and the cell coordinates.
    typedef struct packed {
        logic       wr_en;
        perm_byte_t wr_idx;
        perm_byte_t wr_data;
        perm_byte_t cx;
        perm_byte_t cy;
    } perm_req_t;

    // Second level hashes of the four cell corners.
    typedef struct packed {
        perm_byte_t aa;
        perm_byte_t ab;
        perm_byte_t ba;
        perm_byte_t bb;
    } corner_hash_t;

endpackage

@@ rtl/pn2d_if.sv @@
// Command channel: table loads and noise evaluations.
interface pn2d_cmd_if;
    import pn2d_pkg::*;

    logic               valid;
    logic               ready;
    logic               opcode;
    logic [COORD_W-1:0] x_pos;
    logic [COORD_W-1:0] y_pos;
    logic [IDX_W-1:0]   load_index;
    logic [IDX_W-1:0]   load_value;

    modport source (
        output valid, opcode, x_pos, y_pos, load_index, load_value,
        input  ready
    );

    modport sink (
        input  valid, opcode, x_pos, y_pos, load_index, load_value,
        output ready
    );
endinterface

// Response channel: one noise value per evaluation.
interface pn2d_rsp_if;
    import pn2d_pkg::*;

    logic               valid;
    logic               ready;
    logic [NOISE_W-1:0] noise_value;

    modport source (
        output valid, noise_value,
        input  ready
    );

    modport sink (
        input  valid, noise_value,
        output ready
    );
endinterface

@@ rtl/perlin_noise_2d_unit.sv @@
// Channel | Modport            | Item
// --------+--------------------+----------------------------------------------
// cmd     | pn2d_cmd_if.sink   | opcode, x_pos, y_pos, load_index, load_value
// rsp     | pn2d_rsp_if.source | noise_value (one per evaluate item)
//
// One item is taken per clock while cmd.ready is high, loads and evaluations alike.
// An evaluation passes the two table lookups and the fade and lerp multiplier
// stages before its result enters the output queue.
// Up to QUEUE_DEPTH evaluations may be outstanding; cmd.ready drops while
// that many have not been taken from rsp, so a stall on rsp holds cmd.
// The table has no reset value; all 256 entries must be loaded before the
// first evaluation, and no clearing pass runs after reset.
module perlin_noise_2d_unit #(
    parameter int FRAC_BITS   = pn2d_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = pn2d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pn2d_cmd_if.sink    cmd,
    pn2d_rsp_if.source  rsp
);
    import pn2d_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH + 1);

    logic [PW-1:0]        pend_reg;
    logic [PW-1:0]        pend_next;
    logic                 cmd_fire;
    logic                 eval_fire;
    logic                 rsp_fire;
    logic [COORD_W-1:0]   x_int;
    logic [COORD_W-1:0]   y_int;
    perm_req_t            perm_req;
    corner_hash_t         corner_hash;
    logic                 res_valid;
    logic [NOISE_W-1:0]   res_value;

    assign cmd.ready = (pend_reg < PW'(QUEUE_DEPTH));
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign eval_fire = cmd_fire && (cmd.opcode == OP_EVAL);
    assign rsp_fire  = rsp.valid && rsp.ready;

    // Count of evaluations taken whose results have not been delivered.
    always_comb
    begin
        case ({eval_fire, rsp_fire})
            2'b10:   pend_next = pend_reg + PW'(1);
            2'b01:   pend_next = pend_reg - PW'(1);
            default: pend_next = pend_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // Integer parts wrap to the 256-entry lattice.
    assign x_int = cmd.x_pos >> FRAC_BITS;
    assign y_int = cmd.y_pos >> FRAC_BITS;

    assign perm_req.wr_en   = cmd_fire && (cmd.opcode == OP_LOAD);
    assign perm_req.wr_idx  = cmd.load_index;
    assign perm_req.wr_data = cmd.load_value;
    assign perm_req.cx      = x_int[IDX_W-1:0];
    assign perm_req.cy      = y_int[IDX_W-1:0];

    pn2d_perm_mem u_perm_mem (
        .clk  (clk),
        .req  (perm_req),
        .hash (corner_hash)
    );

    pn2d_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .eval_en   (eval_fire),
        .x_frac    (cmd.x_pos[FRAC_BITS-1:0]),
        .y_frac    (cmd.y_pos[FRAC_BITS-1:0]),
        .hash      (corner_hash),
        .res_valid (res_valid),
        .res_value (res_value)
    );

    pn2d_out_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res_value),
        .pop_valid (rsp.valid),
        .pop_ready (rsp.ready),
        .pop_data  (rsp.noise_value)
    );

endmodule

@@ rtl/pn2d_perm_mem.sv @@
module pn2d_perm_mem (
    input  logic                  clk,
    input  pn2d_pkg::perm_req_t    req,
    output pn2d_pkg::corner_hash_t hash
);
    import pn2d_pkg::*;

    localparam int BANK_DEPTH = PERM_DEPTH / 2;
    localparam int BAW        = IDX_W - 1;

    // First level copy, read at cx and cx+1.
    perm_byte_t lvl1_mem [PERM_DEPTH];
    // Second level copy split into even and odd entries, so that the two
    // consecutive entries of a corner pair always fall in different banks.
    perm_byte_t even_mem [BANK_DEPTH];
    perm_byte_t odd_mem  [BANK_DEPTH];

    perm_byte_t pa_reg;
    perm_byte_t pb_reg;
    perm_byte_t cy_reg;
    perm_byte_t ea_reg;
    perm_byte_t oa_reg;
    perm_byte_t eb_reg;
    perm_byte_t ob_reg;
    logic       swap_a_reg;
    logic       swap_b_reg;

    perm_byte_t cx_next;
    perm_byte_t a_lo;
    perm_byte_t a_hi;
    perm_byte_t b_lo;
    perm_byte_t b_hi;
    logic [BAW-1:0] even_idx_a;
    logic [BAW-1:0] even_idx_b;

    assign cx_next = req.cx + perm_byte_t'(1);

    // Table writes go to both copies in the same cycle.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            lvl1_mem[req.wr_idx] <= req.wr_data;
            if (req.wr_idx[0])
            begin
                odd_mem[req.wr_idx[IDX_W-1:1]] <= req.wr_data;
            end
            else
            begin
                even_mem[req.wr_idx[IDX_W-1:1]] <= req.wr_data;
            end
        end
    end

    // First level read: the hashes of the two cell columns.
    always_ff @(posedge clk)
    begin
        pa_reg <= lvl1_mem[req.cx];
        pb_reg <= lvl1_mem[cx_next];
        cy_reg <= req.cy;
    end

    // Second level addresses; an odd low address takes its pair from the
    // next even entry, which wraps to entry zero at the top of the table.
    assign a_lo = pa_reg + cy_reg;
    assign a_hi = a_lo + perm_byte_t'(1);
    assign b_lo = pb_reg + cy_reg;
    assign b_hi = b_lo + perm_byte_t'(1);

    assign even_idx_a = a_lo[0] ? a_hi[IDX_W-1:1] : a_lo[IDX_W-1:1];
    assign even_idx_b = b_lo[0] ? b_hi[IDX_W-1:1] : b_lo[IDX_W-1:1];

    // Second level read: two ports on each bank.
    always_ff @(posedge clk)
    begin
        ea_reg     <= even_mem[even_idx_a];
        oa_reg     <= odd_mem[a_lo[IDX_W-1:1]];
        eb_reg     <= even_mem[even_idx_b];
        ob_reg     <= odd_mem[b_lo[IDX_W-1:1]];
        swap_a_reg <= a_lo[0];
        swap_b_reg <= b_lo[0];
    end

    // Put the bank outputs back in corner order.
    assign hash.aa = swap_a_reg ? oa_reg : ea_reg;
    assign hash.ab = swap_a_reg ? ea_reg : oa_reg;
    assign hash.ba = swap_b_reg ? ob_reg : eb_reg;
    assign hash.bb = swap_b_reg ? eb_reg : ob_reg;

endmodule

@@ rtl/pn2d_datapath.sv @@
module pn2d_datapath #(
    parameter int FRAC_BITS = pn2d_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           eval_en,
    input  logic [FRAC_BITS-1:0]           x_frac,
    input  logic [FRAC_BITS-1:0]           y_frac,
    input  pn2d_pkg::corner_hash_t         hash,
    output logic                           res_valid,
    output logic [pn2d_pkg::NOISE_W-1:0]   res_value
);
    import pn2d_pkg::*;

    localparam int STAGES = 8;

    // Signed widths of the intermediate values.
    localparam int TW  = FRAC_BITS + 1;  // fraction, tt, cube
    localparam int AW1 = FRAC_BITS + 5;  // 6t-15 and the fade inner term
    localparam int P1W = TW + AW1;
    localparam int PSQ = 2 * TW;
    localparam int FW  = FRAC_BITS + 2;  // fade
    localparam int GW  = FRAC_BITS + 3;  // gradient dot products
    localparam int DW  = FRAC_BITS + 4;  // first lerp inputs and results
    localparam int PLW = FW + DW;
    localparam int EW  = FRAC_BITS + 5;  // second lerp span
    localparam int PEW = FW + EW;
    localparam int RW  = FRAC_BITS + 5;  // noise before offset
    localparam int VFW = RW + 1;
    localparam int VW  = FRAC_BITS + 2;  // clamped res+1 in [0, 2]
    localparam int SHIFT = FRAC_BITS + 1 - 16;

    localparam longint QONE      = longint'(1) << FRAC_BITS;
    localparam longint TWO_Q     = QONE * 2;
    localparam longint TEN_Q     = QONE * 10;
    localparam longint FIFTEEN_Q = QONE * 15;
    localparam longint HALF      = longint'(1) << (FRAC_BITS - 1);

    // Gradient rule of improved noise, on the low four hash bits.
    function automatic logic signed [GW-1:0] grad(
        input logic [3:0]              h,
        input logic signed [GW-1:0]    gx,
        input logic signed [GW-1:0]    gy
    );
        logic signed [GW-1:0] gu;
        logic signed [GW-1:0] gv;
        gu = h[3] ? gy : gx;
        if (h < 4'd4)
        begin
            gv = gy;
        end
        else if (h == 4'd12 || h == 4'd14)
        begin
            gv = gx;
        end
        else
        begin
            gv = '0;
        end
        return (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
    endfunction

    logic [STAGES-1:0] vld_reg;

    logic signed [TW-1:0]  s1_t_reg     [2];
    logic signed [TW-1:0]  s2_t_reg     [2];
    logic signed [AW1-1:0] s2_m1_reg    [2];
    logic signed [TW-1:0]  s2_tt_reg    [2];
    logic signed [AW1-1:0] s3_inner_reg [2];
    logic signed [TW-1:0]  s3_cube_reg  [2];
    logic signed [FW-1:0]  s4_fade_reg  [2];

    logic signed [GW-1:0]  s3_g00_reg;
    logic signed [GW-1:0]  s3_g10_reg;
    logic signed [GW-1:0]  s3_g01_reg;
    logic signed [GW-1:0]  s3_g11_reg;
    logic signed [DW-1:0]  s4_d0_reg;
    logic signed [DW-1:0]  s4_d1_reg;
    logic signed [GW-1:0]  s4_a0_reg;
    logic signed [GW-1:0]  s4_a1_reg;
    logic signed [DW-1:0]  s5_x1_reg;
    logic signed [DW-1:0]  s5_x2_reg;
    logic signed [FW-1:0]  s5_v_reg;
    logic signed [EW-1:0]  s6_diff_reg;
    logic signed [DW-1:0]  s6_x1_reg;
    logic signed [FW-1:0]  s6_v_reg;
    logic signed [RW-1:0]  s7_res_reg;
    logic [NOISE_W-1:0]    s8_noise_reg;

    logic signed [AW1-1:0] a1       [2];
    logic signed [P1W-1:0] m1_prod  [2];
    logic signed [PSQ-1:0] sq_prod  [2];
    logic signed [PSQ-1:0] cube_prod[2];
    logic signed [P1W-1:0] fade_prod[2];

    logic signed [GW-1:0]  gx0;
    logic signed [GW-1:0]  gx1;
    logic signed [GW-1:0]  gy0;
    logic signed [GW-1:0]  gy1;
    logic signed [PLW-1:0] lerp0_prod;
    logic signed [PLW-1:0] lerp1_prod;
    logic signed [PEW-1:0] lerp2_prod;
    logic signed [VFW-1:0] val_full;
    logic [VW-1:0]         val_c;
    logic [NOISE_W-1:0]    scaled;

    // Valid bits follow each evaluation down the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[STAGES-2:0], eval_en};
        end
    end

    // Fade products for both axes; every product is rounded half up.
    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            a1[c]        = AW1'(s1_t_reg[c]) * AW1'(6) - AW1'(FIFTEEN_Q);
            m1_prod[c]   = P1W'(s1_t_reg[c]) * P1W'(a1[c]) + P1W'(HALF);
            sq_prod[c]   = PSQ'(s1_t_reg[c]) * PSQ'(s1_t_reg[c]) + PSQ'(HALF);
            cube_prod[c] = PSQ'(s2_tt_reg[c]) * PSQ'(s2_t_reg[c]) + PSQ'(HALF);
            fade_prod[c] = P1W'(s3_cube_reg[c]) * P1W'(s3_inner_reg[c]) + P1W'(HALF);
        end
    end

    // Fade stages: fraction in, t*(6t-15) and t*t, then inner and cube,
    // then the fade itself.
    always_ff @(posedge clk)
    begin
        s1_t_reg[0] <= TW'(x_frac);
        s1_t_reg[1] <= TW'(y_frac);
        for (int c = 0; c < 2; c++)
        begin
            s2_t_reg[c]     <= s1_t_reg[c];
            s2_m1_reg[c]    <= AW1'(m1_prod[c] >>> FRAC_BITS);
            s2_tt_reg[c]    <= TW'(sq_prod[c] >>> FRAC_BITS);
            s3_inner_reg[c] <= s2_m1_reg[c] + AW1'(TEN_Q);
            s3_cube_reg[c]  <= TW'(cube_prod[c] >>> FRAC_BITS);
            s4_fade_reg[c]  <= FW'(fade_prod[c] >>> FRAC_BITS);
        end
    end

    // Corner offsets relative to the sample point.
    always_comb
    begin
        gx0 = GW'(s2_t_reg[0]);
        gx1 = gx0 - GW'(QONE);
        gy0 = GW'(s2_t_reg[1]);
        gy1 = gy0 - GW'(QONE);
    end

    // Gradients arrive together with the second level hashes.
    always_ff @(posedge clk)
    begin
        s3_g00_reg <= grad(hash.aa[3:0], gx0, gy0);
        s3_g10_reg <= grad(hash.ba[3:0], gx1, gy0);
        s3_g01_reg <= grad(hash.ab[3:0], gx0, gy1);
        s3_g11_reg <= grad(hash.bb[3:0], gx1, gy1);
    end

    // Lerp spans along x.
    always_ff @(posedge clk)
    begin
        s4_d0_reg <= DW'(s3_g10_reg) - DW'(s3_g00_reg);
        s4_d1_reg <= DW'(s3_g11_reg) - DW'(s3_g01_reg);
        s4_a0_reg <= s3_g00_reg;
        s4_a1_reg <= s3_g01_reg;
    end

    // The two lerps along x, then the span and the lerp along y.
    assign lerp0_prod = PLW'(s4_fade_reg[0]) * PLW'(s4_d0_reg) + PLW'(HALF);
    assign lerp1_prod = PLW'(s4_fade_reg[0]) * PLW'(s4_d1_reg) + PLW'(HALF);
    assign lerp2_prod = PEW'(s6_v_reg) * PEW'(s6_diff_reg) + PEW'(HALF);

    always_ff @(posedge clk)
    begin
        s5_x1_reg   <= DW'(s4_a0_reg) + DW'(lerp0_prod >>> FRAC_BITS);
        s5_x2_reg   <= DW'(s4_a1_reg) + DW'(lerp1_prod >>> FRAC_BITS);
        s5_v_reg    <= s4_fade_reg[1];
        s6_diff_reg <= EW'(s5_x2_reg) - EW'(s5_x1_reg);
        s6_x1_reg   <= s5_x1_reg;
        s6_v_reg    <= s5_v_reg;
        s7_res_reg  <= RW'(s6_x1_reg) + RW'(lerp2_prod >>> FRAC_BITS);
    end

    // Offset by one and clamp to [0, 2].
    always_comb
    begin
        val_full = VFW'(s7_res_reg) + VFW'(QONE);
        if (val_full < 0)
        begin
            val_c = '0;
        end
        else if (val_full > VFW'(TWO_Q))
        begin
            val_c = VW'(TWO_Q);
        end
        else
        begin
            val_c = VW'(val_full);
        end
    end

    // Halve and bring to sixteen fraction bits.
    if (SHIFT > 0)
    begin : g_round_down
        localparam longint RND = longint'(1) << (SHIFT - 1);
        logic [VW:0] val_rnd;
        assign val_rnd = (VW + 1)'(val_c) + (VW + 1)'(RND);
        assign scaled  = NOISE_W'(val_rnd >> SHIFT);
    end
    else
    begin : g_widen
        localparam int LSH = -SHIFT;
        assign scaled = NOISE_W'(val_c) << LSH;
    end

    always_ff @(posedge clk)
    begin
        s8_noise_reg <= scaled;
    end

    assign res_valid = vld_reg[STAGES-1];
    assign res_value = s8_noise_reg;

endmodule

@@ rtl/pn2d_out_fifo.sv @@
module pn2d_out_fifo #(
    parameter int DEPTH = pn2d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [pn2d_pkg::NOISE_W-1:0] push_data,
    output logic                         pop_valid,
    input  logic                         pop_ready,
    output logic [pn2d_pkg::NOISE_W-1:0] pop_data
);
    import pn2d_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [NOISE_W-1:0] slot_reg [DEPTH];
    logic [AW-1:0]      wr_ptr_reg;
    logic [AW-1:0]      rd_ptr_reg;
    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      wr_ptr_next;
    logic [AW-1:0]      rd_ptr_next;
    logic [CW-1:0]      count_next;
    logic               pop;

    assign pop = pop_valid && pop_ready;

    // Pointer and fill count updates; the caller never pushes into a full queue.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_valid = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

endmodule

@@ rtl/pn2d_checker.sv @@
module pn2d_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cmd_valid,
    input logic                         cmd_ready,
    input logic                         cmd_opcode,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [pn2d_pkg::NOISE_W-1:0] noise_value
);
    import pn2d_pkg::*;

    logic [15:0] outstanding_reg;
    logic        eval_taken;
    logic        rsp_taken;

    assign eval_taken = cmd_valid && cmd_ready && (cmd_opcode == OP_EVAL);
    assign rsp_taken  = rsp_valid && rsp_ready;

    // Evaluations seen on the ports whose results have not been taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_reg + 16'(eval_taken) - 16'(rsp_taken);
        end
    end

    // A result only shows while an evaluation is owed.
    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> outstanding_reg != '0)
        else $error("result offered with no evaluation outstanding");

    // With nothing owed the block must take a new item.
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg == '0 |-> cmd_ready)
        else $error("idle block does not accept an item");

    // Noise stays within [0, 1.0].
    a_noise_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> noise_value <= NOISE_MAX)
        else $error("noise value above 1.0");

    // A stalled result holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(noise_value))
        else $error("stalled result changed or dropped");

endmodule

bind perlin_noise_2d_unit pn2d_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .cmd_opcode  (cmd.opcode),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .noise_value (rsp.noise_value)
);

@@ bench/perlin_noise_2d_unit_checker.sv @@
// Passive checker for the Perlin noise unit: it mirrors the permutation
// table from the load items it sees, predicts the noise value of every
// accepted evaluate item and compares each returned item in order.
module perlin_noise_2d_unit_checker #(
    parameter int FRAC_BITS = pn2d_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    pn2d_cmd_if  cmd,
    pn2d_rsp_if  rsp,
    output int   mismatches,
    output int   pending,
    output int   compared
);
    import pn2d_pkg::*;

    localparam longint ONE       = longint'(1) << FRAC_BITS;
    localparam longint HALF      = ONE >>> 1;
    localparam int     OUT_SHIFT = FRAC_BITS + 1 - 16;
    localparam int     REPORT_MAX = 10;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [NOISE_W-1:0] noise;
    } noise_sample_t;

    perm_byte_t    perm_copy [PERM_DEPTH];
    noise_sample_t pending_noise [$];

    // Product of two fixed-point values, rounded half up back to the same format.
    function automatic longint fx_mul(longint a, longint b);
        return (a * b + HALF) >>> FRAC_BITS;
    endfunction

    // Quintic fade 6t^5 - 15t^4 + 10t^3, rounded after every product.
    function automatic longint fade(longint t);
        longint inner;
        longint cube;
        inner = fx_mul(t, t * 6 - 15 * ONE) + 10 * ONE;
        cube  = fx_mul(fx_mul(t, t), t);
        return fx_mul(cube, inner);
    endfunction

    function automatic longint lerp(longint t, longint a, longint b);
        return a + fx_mul(t, b - a);
    endfunction

    // Improved Perlin gradient: the low four hash bits pick one of 16 rules.
    function automatic longint grad(perm_byte_t hash, longint x, longint y);
        logic [3:0] h;
        longint     u;
        longint     v;
        h = hash[3:0];
        u = (h < 4'd8) ? x : y;
        v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : 0);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    // Noise at one point, scaled to (res+1)/2 in Q1.16 and saturated.
    function automatic logic [NOISE_W-1:0] noise_at(logic [COORD_W-1:0] x,
                                                    logic [COORD_W-1:0] y);
        longint     fx;
        longint     fy;
        longint     u;
        longint     v;
        longint     res;
        longint     val;
        longint     scaled;
        int         cx;
        int         cy;
        perm_byte_t pa;
        perm_byte_t pb;
        perm_byte_t aa;
        perm_byte_t ab;
        perm_byte_t ba;
        perm_byte_t bb;

        cx = int'((longint'(x) >> FRAC_BITS) & 255);
        cy = int'((longint'(y) >> FRAC_BITS) & 255);
        fx = longint'(x) & (ONE - 1);
        fy = longint'(y) & (ONE - 1);
        u  = fade(fx);
        v  = fade(fy);

        // Two levels of table lookup hash the four cell corners.
        pa = perm_copy[cx];
        pb = perm_copy[(cx + 1) & 255];
        aa = perm_copy[(int'(pa) + cy) & 255];
        ab = perm_copy[(int'(pa) + cy + 1) & 255];
        ba = perm_copy[(int'(pb) + cy) & 255];
        bb = perm_copy[(int'(pb) + cy + 1) & 255];

        res = lerp(v,
                   lerp(u, grad(aa, fx, fy), grad(ba, fx - ONE, fy)),
                   lerp(u, grad(ab, fx, fy - ONE), grad(bb, fx - ONE, fy - ONE)));

        val = res + ONE;
        if (val < 0)
        begin
            val = 0;
        end
        if (val > 2 * ONE)
        begin
            val = 2 * ONE;
        end

        if (OUT_SHIFT > 0)
        begin
            scaled = (val + (longint'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
        end
        else
        begin
            scaled = val << (-OUT_SHIFT);
        end
        if (scaled > 65536)
        begin
            scaled = 65536;
        end
        return NOISE_W'(scaled);
    endfunction

    // Track accepted commands and returned results at each rising edge.
    always @(posedge clk)
    begin : watch
        noise_sample_t want;
        if (rst_n)
        begin
            if (cmd.valid && cmd.ready)
            begin
                if (opcode_t'(cmd.opcode) == OP_LOAD)
                begin
                    perm_copy[cmd.load_index] = cmd.load_value;
                end
                else
                begin
                    want.x     = cmd.x_pos;
                    want.y     = cmd.y_pos;
                    want.noise = noise_at(cmd.x_pos, cmd.y_pos);
                    pending_noise.push_back(want);
                end
            end

            if (rsp.valid && rsp.ready)
            begin
                if (pending_noise.size() == 0)
                begin
                    if (mismatches < REPORT_MAX)
                    begin
                        $display("Unexpected noise item %0d with no evaluation waiting",
                                 rsp.noise_value);
                    end
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = pending_noise.pop_front();
                    compared = compared + 1;
                    if (rsp.noise_value !== want.noise)
                    begin
                        if (mismatches < REPORT_MAX)
                        begin
                            $display("Noise mismatch at x=%h y=%h: expected %0d, got %0d",
                                     want.x, want.y, want.noise, rsp.noise_value);
                        end
                        mismatches = mismatches + 1;
                    end
                end
            end
            pending = pending_noise.size();
        end
    end

endmodule

@@ bench/perlin_noise_2d_unit_tb.sv @@
// Stimulus and verdict for the Perlin noise unit. The table is loaded in
// full, directed points run, then random traffic runs through four pacing
// phases while the checker compares every noise value.
module perlin_noise_2d_unit_tb;
    import pn2d_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_ITEMS  = 343;
    localparam int DRAIN_CYCLES = 24;

    logic clk = 1'b0;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;
    int   cycle_count;
    int   load_count;
    int   eval_count;
    int   mismatches;
    int   pending;
    int   compared;

    pn2d_cmd_if cmd_ch ();
    pn2d_rsp_if rsp_ch ();

    perlin_noise_2d_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    perlin_noise_2d_unit_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .rsp        (rsp_ch),
        .mismatches (mismatches),
        .pending    (pending),
        .compared   (compared)
    );

    // Clock generation.
    always #5 clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Run exceeded %0d cycles", LIMIT_CYCLES);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side back-pressure, changed at the falling edge.
    always @(negedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Present one item after a random gap and hold it until it is accepted.
    task automatic drive_item(opcode_t op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              perm_byte_t idx, perm_byte_t val);
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.opcode     <= op;
        cmd_ch.x_pos      <= x;
        cmd_ch.y_pos      <= y;
        cmd_ch.load_index <= idx;
        cmd_ch.load_value <= val;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Loads carry random coordinates, which the block must ignore.
    task automatic load_entry(perm_byte_t idx, perm_byte_t val);
        drive_item(OP_LOAD, COORD_W'($urandom), COORD_W'($urandom), idx, val);
        load_count++;
    endtask

    // Evaluations carry random load fields, which the block must ignore.
    task automatic eval_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        drive_item(OP_EVAL, x, y, IDX_W'($urandom), IDX_W'($urandom));
        eval_count++;
    endtask

    // Random coordinate, with the fraction often at an edge or the middle of its range.
    function automatic logic [COORD_W-1:0] rand_coord();
        logic [15:0] frac;
        case ($urandom_range(9))
            0:       frac = 16'h0000;
            1:       frac = 16'hFFFF;
            2:       frac = 16'h8000;
            default: frac = 16'($urandom);
        endcase
        return {8'($urandom), frac};
    endfunction

    initial
    begin : stimulus
        perm_byte_t order [PERM_DEPTH];
        perm_byte_t tmp;
        int         j;
        int         idle_of  [4];
        int         stall_of [4];

        idle_of  = '{0, 45, 0, 9};
        stall_of = '{0, 0, 45, 9};

        rst_n             = 1'b0;
        idle_pct          = 0;
        stall_pct         = 0;
        load_count        = 0;
        eval_count        = 0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.opcode     = OP_LOAD;
        cmd_ch.x_pos      = '0;
        cmd_ch.y_pos      = '0;
        cmd_ch.load_index = '0;
        cmd_ch.load_value = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill every table entry with a shuffled permutation.
        for (int i = 0; i < PERM_DEPTH; i++)
        begin
            order[i] = perm_byte_t'(i);
        end
        for (int i = PERM_DEPTH - 1; i > 0; i--)
        begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < PERM_DEPTH; i++)
        begin
            load_entry(perm_byte_t'(i), order[i]);
        end

        // Cell (10,20): corner hashes chosen so every gradient gives +1 at the center.
        load_entry(8'd10, 8'd100);
        load_entry(8'd11, 8'd150);
        load_entry(8'd120, 8'd0);
        load_entry(8'd121, 8'd2);
        load_entry(8'd170, 8'd1);
        load_entry(8'd171, 8'd3);
        eval_point({8'd10, 16'h8000}, {8'd20, 16'h8000});

        // Same cell with all gradients at -1 drives the output to its low end.
        load_entry(8'd120, 8'd3);
        load_entry(8'd121, 8'd1);
        load_entry(8'd170, 8'd2);
        load_entry(8'd171, 8'd0);
        eval_point({8'd10, 16'h8000}, {8'd20, 16'h8000});

        // The rules that mix in x for the second term (12, 14), and two that leave it at zero.
        load_entry(8'd120, 8'd12);
        load_entry(8'd121, 8'd14);
        load_entry(8'd170, 8'd13);
        load_entry(8'd171, 8'd255);
        eval_point({8'd10, 16'h4000}, {8'd20, 16'hC000});

        // Coordinate extremes, and the last cell whose neighbor wraps to zero.
        eval_point(24'h000000, 24'h000000);
        eval_point(24'hFFFFFF, 24'hFFFFFF);
        eval_point(24'hFFFFFF, 24'h000000);
        eval_point(24'h000000, 24'hFFFFFF);
        eval_point(24'h00FFFF, 24'h000001);
        eval_point({8'd255, 16'h8000}, {8'd255, 16'h8000});

        // Random traffic under each pacing phase.
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct  = idle_of[phase];
            stall_pct = stall_of[phase];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(99) < 15)
                begin
                    load_entry(IDX_W'($urandom), IDX_W'($urandom));
                end
                else
                begin
                    eval_point(rand_coord(), rand_coord());
                end
            end
        end
        cmd_ch.valid <= 1'b0;

        // Drain outstanding results, then watch for stray ones.
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d table loads and %0d noise evaluations over four pacing phases;",
                 load_count, eval_count);
        $display("%0d noise values compared, %0d mismatches, %0d left unanswered.",
                 compared, mismatches, pending);
        if (mismatches == 0 && pending == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
